// File: rtl/waypoint_follow_controller_unit_macros.svh
// ----------------------------------------------------------------------------
// Waypoint follow controller assertion macros
// Shared concurrent assertion forms for the waypoint follow controller.
// ----------------------------------------------------------------------------
`ifndef WAYPOINT_FOLLOW_CONTROLLER_UNIT_MACROS_SVH
`define WAYPOINT_FOLLOW_CONTROLLER_UNIT_MACROS_SVH

// same-cycle implication
`define WFC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WFC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/wfc_pkg.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller package
// Payload types, command and status groups, codes and constants.
// ----------------------------------------------------------------------------
package wfc_pkg;

    typedef struct packed {
        logic               action;
        logic [7:0]         waypoint_index;
        logic signed [31:0] waypoint_x;
        logic signed [31:0] waypoint_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } wfc_request_t;

    typedef struct packed {
        logic signed [15:0] forward_cmd;
        logic signed [15:0] turn_cmd;
        logic [1:0]         mode;
        logic               reached;
        logic [8:0]         target_index;
    } wfc_result_t;

    typedef struct packed {
        logic [30:0]        tolerance;
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_speed;
        logic signed [15:0] start_heading;
        logic [8:0]         waypoint_count;
    } wfc_cfg_t;

    typedef struct packed {
        logic accept_wr;
        logic accept_od;
        logic diff;
        logic start_mul;
        logic start_yaw;
        logic start_bear;
        logic commit;
    } wfc_cmd_t;

    typedef struct packed {
        logic mul_busy;
        logic cordic_busy;
        logic sqrt_busy;
    } wfc_stat_t;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_ODOM  = 1'b1;

    localparam logic [1:0] MODE_MOVE   = 2'd0;
    localparam logic [1:0] MODE_ALIGN  = 2'd1;
    localparam logic [1:0] MODE_TRACK  = 2'd2;
    localparam logic [1:0] MODE_FINISH = 2'd3;

    localparam logic [2:0] REG_TOLERANCE     = 3'd0;
    localparam logic [2:0] REG_LINEAR_SPEED  = 3'd1;
    localparam logic [2:0] REG_TURN_SPEED    = 3'd2;
    localparam logic [2:0] REG_START_HEADING = 3'd3;
    localparam logic [2:0] REG_WAYPOINT_CNT  = 3'd4;

    localparam logic [30:0] TOLERANCE_RST = 31'd655;
    localparam logic [31:0] DIST_MAX      = 32'h7FFF_FFFF;

    localparam logic signed [15:0] MOVE_SPEED     = 16'sd205;
    localparam logic signed [16:0] ALIGN_DEADBAND = 17'sd25;
    localparam logic signed [31:0] ALIGN_OFFSET   = 32'sd410;
    localparam logic signed [12:0] ALIGN_GAIN     = 13'sd2621;
    localparam logic signed [17:0] DIR_DEADBAND   = 18'sd819;
    localparam logic signed [17:0] TWO_PI_Q13     = 18'sd51472;
    localparam logic signed [15:0] HALF_PI_Q13    = 16'sd12868;
    localparam logic signed [19:0] PI_Q13         = 20'sd25736;
    localparam logic signed [19:0] HALF_PI_Q16    = 20'sd102944;

    function automatic logic signed [19:0] atan_entry(input logic [3:0] i);
        logic signed [19:0] v;
        case (i)
            4'd0:    v = 20'sd51472;
            4'd1:    v = 20'sd30386;
            4'd2:    v = 20'sd16055;
            4'd3:    v = 20'sd8150;
            4'd4:    v = 20'sd4091;
            4'd5:    v = 20'sd2047;
            4'd6:    v = 20'sd1024;
            4'd7:    v = 20'sd512;
            4'd8:    v = 20'sd256;
            4'd9:    v = 20'sd128;
            4'd10:   v = 20'sd64;
            4'd11:   v = 20'sd32;
            4'd12:   v = 20'sd16;
            4'd13:   v = 20'sd8;
            4'd14:   v = 20'sd4;
            default: v = 20'sd2;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/wfc_cordic.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller CORDIC
// Iterative vectoring CORDIC, one rotation per cycle, Q3.13 angle out.
// ----------------------------------------------------------------------------
module wfc_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [34:0] y_in,
    input  logic signed [34:0] x_in,
    output logic               busy,
    output logic signed [15:0] angle
);

    logic signed [63:0] x_reg, x_next;
    logic signed [63:0] y_reg, y_next;
    logic signed [19:0] z_reg, z_next;
    logic [3:0]         i_reg, i_next;
    logic               busy_reg, busy_next;
    logic               zero_reg, zero_next;

    logic signed [63:0] xl, yl, xs, ys;
    logic signed [19:0] r;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        i_next    = i_reg;
        busy_next = busy_reg;
        zero_next = zero_reg;
        xl = 64'(x_in) <<< 24;
        yl = 64'(y_in) <<< 24;
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (start)
        begin
            zero_next = (x_in == '0) && (y_in == '0);
            busy_next = 1'b1;
            i_next    = '0;
            if (xl < 0)
            begin
                if (yl >= 0)
                begin
                    x_next = yl;
                    y_next = -xl;
                    z_next = wfc_pkg::HALF_PI_Q16;
                end
                else
                begin
                    x_next = -yl;
                    y_next = xl;
                    z_next = -wfc_pkg::HALF_PI_Q16;
                end
            end
            else
            begin
                x_next = xl;
                y_next = yl;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + wfc_pkg::atan_entry(i_reg);
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - wfc_pkg::atan_entry(i_reg);
            end
            i_next = i_reg + 4'd1;
            if (i_reg == 4'd15)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            i_reg    <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        zero_reg <= zero_next;
    end

    always_comb
    begin
        r = (z_reg + 20'sd4) >>> 3;
        if (zero_reg)
        begin
            angle = '0;
        end
        else if (r > wfc_pkg::PI_Q13)
        begin
            angle = 16'(wfc_pkg::PI_Q13);
        end
        else if (r < -wfc_pkg::PI_Q13)
        begin
            angle = 16'(-wfc_pkg::PI_Q13);
        end
        else
        begin
            angle = r[15:0];
        end
    end

    assign busy = busy_reg;

endmodule

// File: rtl/wfc_isqrt.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller square root
// Restoring integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module wfc_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] rad_reg, rad_next;
    logic [34:0] rem_reg, rem_next;
    logic [31:0] root_reg, root_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [34:0] rem_sh, trial;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg[32:0], rad_reg[63:62]};
        trial     = {1'b0, root_reg, 2'b01};
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// File: rtl/wfc_datapath.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller datapath
// Waypoint memory, shared multiplier, angle and distance units, mode update.
// ----------------------------------------------------------------------------
module wfc_datapath #(
    parameter int WAYPOINT_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wfc_pkg::wfc_cmd_t    cmd,
    output wfc_pkg::wfc_stat_t   stat,
    input  wfc_pkg::wfc_request_t request,
    input  wfc_pkg::wfc_cfg_t    cfg,
    output wfc_pkg::wfc_result_t result
);

    localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
    localparam int TW = (AW > 9) ? AW : 9;

    localparam logic [3:0] P_WW = 4'd0;
    localparam logic [3:0] P_XX = 4'd1;
    localparam logic [3:0] P_YY = 4'd2;
    localparam logic [3:0] P_ZZ = 4'd3;
    localparam logic [3:0] P_WZ = 4'd4;
    localparam logic [3:0] P_XY = 4'd5;
    localparam logic [3:0] P_XZ = 4'd6;
    localparam logic [3:0] P_WY = 4'd7;
    localparam logic [3:0] P_AX = 4'd8;
    localparam logic [3:0] P_AY = 4'd9;

    logic [63:0] mem [WAYPOINT_DEPTH];
    logic [63:0] rd_reg;

    logic signed [31:0] px_reg, py_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic [32:0]        ax_reg, ay_reg;

    logic               mul_run_reg;
    logic [3:0]         mul_idx_reg;
    logic               tag_v_reg;
    logic [3:0]         tag_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] opa, opb;

    logic signed [35:0] d_acc_reg, den_acc_reg, num_acc_reg, g_acc_reg;
    logic [63:0]        sq_acc_reg;
    logic signed [35:0] p36;

    logic [1:0]  mode_reg;
    logic [8:0]  target_reg;
    logic [31:0] last_reg;
    logic signed [15:0] yaw_reg;

    logic [TW-1:0] rd_ext, wr_ext;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          wr_ok;

    logic signed [34:0] cy, cx;
    logic               cordic_busy, sqrt_busy;
    logic signed [15:0] angle;
    logic [31:0]        root;
    logic               gimbal;
    logic signed [36:0] g2, g2_mag;

    always_comb
    begin
        rd_ext  = TW'(target_reg);
        rd_addr = (mode_reg == wfc_pkg::MODE_MOVE) ? '0 : rd_ext[AW-1:0];
        wr_ext  = TW'(request.waypoint_index);
        wr_addr = wr_ext[AW-1:0];
        wr_ok   = 32'(request.waypoint_index) < WAYPOINT_DEPTH;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_wr && wr_ok)
        begin
            mem[wr_addr] <= {request.waypoint_x, request.waypoint_y};
        end
        if (cmd.accept_od)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_od)
        begin
            px_reg <= request.pos_x;
            py_reg <= request.pos_y;
            qw_reg <= request.quat_w;
            qx_reg <= request.quat_x;
            qy_reg <= request.quat_y;
            qz_reg <= request.quat_z;
        end
        if (cmd.diff)
        begin
            dx_reg <= 33'($signed(rd_reg[63:32])) - 33'(px_reg);
            dy_reg <= 33'($signed(rd_reg[31:0])) - 33'(py_reg);
        end
    end

    always_comb
    begin
        ax_reg = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        ay_reg = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
    end

    always_comb
    begin
        case (mul_idx_reg)
            P_WW:    begin opa = 32'(qw_reg); opb = 32'(qw_reg); end
            P_XX:    begin opa = 32'(qx_reg); opb = 32'(qx_reg); end
            P_YY:    begin opa = 32'(qy_reg); opb = 32'(qy_reg); end
            P_ZZ:    begin opa = 32'(qz_reg); opb = 32'(qz_reg); end
            P_WZ:    begin opa = 32'(qw_reg); opb = 32'(qz_reg); end
            P_XY:    begin opa = 32'(qx_reg); opb = 32'(qy_reg); end
            P_XZ:    begin opa = 32'(qx_reg); opb = 32'(qz_reg); end
            P_WY:    begin opa = 32'(qw_reg); opb = 32'(qy_reg); end
            P_AX:    begin opa = $signed(ax_reg[31:0]); opb = $signed(ax_reg[31:0]); end
            default: begin opa = $signed(ay_reg[31:0]); opb = $signed(ay_reg[31:0]); end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_run_reg <= 1'b0;
            mul_idx_reg <= '0;
            tag_v_reg   <= 1'b0;
        end
        else
        begin
            tag_v_reg <= mul_run_reg;
            if (cmd.start_mul)
            begin
                mul_run_reg <= 1'b1;
                mul_idx_reg <= '0;
            end
            else if (mul_run_reg)
            begin
                mul_idx_reg <= mul_idx_reg + 4'd1;
                if (mul_idx_reg == P_AY)
                begin
                    mul_run_reg <= 1'b0;
                end
            end
        end
    end

    assign p36 = $signed(prod_reg[35:0]);

    always_ff @(posedge clk)
    begin
        prod_reg <= opa * opb;
        tag_reg  <= mul_idx_reg;
        if (cmd.start_mul)
        begin
            d_acc_reg   <= '0;
            den_acc_reg <= '0;
            num_acc_reg <= '0;
            g_acc_reg   <= '0;
            sq_acc_reg  <= '0;
        end
        else if (tag_v_reg)
        begin
            case (tag_reg)
                P_WW, P_XX:
                begin
                    d_acc_reg   <= d_acc_reg + p36;
                    den_acc_reg <= den_acc_reg + p36;
                end
                P_YY, P_ZZ:
                begin
                    d_acc_reg   <= d_acc_reg + p36;
                    den_acc_reg <= den_acc_reg - p36;
                end
                P_WZ, P_XY: num_acc_reg <= num_acc_reg + p36;
                P_XZ:       g_acc_reg   <= g_acc_reg + p36;
                P_WY:       g_acc_reg   <= g_acc_reg - p36;
                default:    sq_acc_reg  <= sq_acc_reg + prod_reg;
            endcase
        end
    end

    always_comb
    begin
        g2     = {g_acc_reg, 1'b0};
        g2_mag = g2[36] ? -g2 : g2;
        gimbal = g2_mag >= 37'(d_acc_reg);
        if (cmd.start_yaw)
        begin
            cy = 35'({num_acc_reg, 1'b0});
            cx = 35'(den_acc_reg);
        end
        else
        begin
            cy = 35'(dy_reg);
            cx = 35'(dx_reg);
        end
    end

    wfc_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_yaw || cmd.start_bear),
        .y_in  (cy),
        .x_in  (cx),
        .busy  (cordic_busy),
        .angle (angle)
    );

    wfc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.start_yaw),
        .radicand (sq_acc_reg),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.start_bear)
        begin
            yaw_reg <= gimbal ? '0 : angle;
        end
    end

    assign stat.mul_busy    = mul_run_reg || tag_v_reg;
    assign stat.cordic_busy = cordic_busy;
    assign stat.sqrt_busy   = sqrt_busy;

    // step decision
    logic [1:0]         mode_next;
    logic [8:0]         target_next;
    logic [31:0]        last_next;
    logic signed [15:0] fwd, turn;
    logic               reached;
    logic [31:0]        span;
    logic               big, done_now, done_after;
    logic [8:0]         target_inc;
    logic signed [16:0] diff, diff_mag;
    logic signed [29:0] gain_prod;
    logic signed [31:0] align_turn;
    logic signed [17:0] e1, e2, e3;
    logic               dead;
    logic signed [1:0]  dir;

    always_comb
    begin
        big        = (ax_reg[32:31] != 2'b00) || (ay_reg[32:31] != 2'b00);
        span       = (big || root[31]) ? wfc_pkg::DIST_MAX : root;
        target_inc = target_reg + 9'd1;
        done_now   = (target_reg >= cfg.waypoint_count) ||
                     (32'(target_reg) >= WAYPOINT_DEPTH);
        done_after = (target_inc >= cfg.waypoint_count) ||
                     (32'(target_inc) >= WAYPOINT_DEPTH);

        diff       = 17'(cfg.start_heading) - 17'(yaw_reg);
        diff_mag   = diff[16] ? -diff : diff;
        gain_prod  = 30'(diff) * 30'(wfc_pkg::ALIGN_GAIN);
        align_turn = (diff > 0 ? wfc_pkg::ALIGN_OFFSET : -wfc_pkg::ALIGN_OFFSET) +
                     ((32'(gain_prod) + 32'sd65536) >>> 17);

        e1   = 18'(angle) - 18'(yaw_reg);
        e2   = wfc_pkg::TWO_PI_Q13 + e1;
        e3   = wfc_pkg::TWO_PI_Q13 - e1;
        dead = ((e1[17] ? -e1 : e1) < wfc_pkg::DIR_DEADBAND) ||
               ((e2[17] ? -e2 : e2) < wfc_pkg::DIR_DEADBAND) ||
               ((e3[17] ? -e3 : e3) < wfc_pkg::DIR_DEADBAND);
        if (dead)
        begin
            dir = 2'sd0;
        end
        else if (angle > yaw_reg)
        begin
            dir = (angle > wfc_pkg::HALF_PI_Q13 && yaw_reg < -wfc_pkg::HALF_PI_Q13) ?
                  -2'sd1 : 2'sd1;
        end
        else
        begin
            dir = (angle < -wfc_pkg::HALF_PI_Q13 && yaw_reg > wfc_pkg::HALF_PI_Q13) ?
                  2'sd1 : -2'sd1;
        end

        mode_next   = mode_reg;
        target_next = target_reg;
        last_next   = last_reg;
        fwd         = '0;
        turn        = '0;
        reached     = 1'b0;
        case (mode_reg)
            wfc_pkg::MODE_MOVE:
            begin
                fwd = wfc_pkg::MOVE_SPEED;
                if (ax_reg < {2'b00, cfg.tolerance})
                begin
                    mode_next = wfc_pkg::MODE_ALIGN;
                end
            end
            wfc_pkg::MODE_ALIGN:
            begin
                if (diff_mag > wfc_pkg::ALIGN_DEADBAND)
                begin
                    turn = align_turn[15:0];
                end
                else
                begin
                    mode_next = wfc_pkg::MODE_TRACK;
                end
            end
            default:
            begin
                if (done_now)
                begin
                    mode_next = wfc_pkg::MODE_FINISH;
                end
                else if (span >= last_reg)
                begin
                    reached     = 1'b1;
                    target_next = target_inc;
                    last_next   = wfc_pkg::DIST_MAX;
                    mode_next   = done_after ? wfc_pkg::MODE_FINISH : wfc_pkg::MODE_TRACK;
                end
                else
                begin
                    mode_next = wfc_pkg::MODE_TRACK;
                    fwd       = cfg.linear_speed;
                    last_next = span;
                    if (dir == 2'sd1)
                    begin
                        turn = cfg.turn_speed;
                    end
                    else if (dir == -2'sd1)
                    begin
                        turn = (cfg.turn_speed == -16'sd32768) ? 16'sd32767 : -cfg.turn_speed;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= wfc_pkg::MODE_MOVE;
            target_reg <= 9'd1;
            last_reg   <= wfc_pkg::DIST_MAX;
        end
        else if (cmd.commit)
        begin
            mode_reg   <= mode_next;
            target_reg <= target_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            result.forward_cmd  <= fwd;
            result.turn_cmd     <= turn;
            result.mode         <= mode_next;
            result.reached      <= reached;
            result.target_index <= target_next;
        end
    end

endmodule

// File: rtl/wfc_ctrl.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller sequencer
// Steps one odometry request through the datapath and holds the result valid.
// ----------------------------------------------------------------------------
module wfc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               request_valid,
    input  logic               request_action,
    output logic               request_ready,
    output logic               result_valid,
    input  logic               result_ready,
    output wfc_pkg::wfc_cmd_t  cmd,
    input  wfc_pkg::wfc_stat_t stat
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIFF  = 4'd1;
    localparam logic [3:0] S_MULS  = 4'd2;
    localparam logic [3:0] S_MULW  = 4'd3;
    localparam logic [3:0] S_YAWS  = 4'd4;
    localparam logic [3:0] S_YAWW  = 4'd5;
    localparam logic [3:0] S_BEARS = 4'd6;
    localparam logic [3:0] S_BEARW = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        out_free   = !valid_reg || result_ready;
        valid_next = valid_reg && !result_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    if (request_action == wfc_pkg::ACT_ODOM)
                    begin
                        cmd.accept_od = 1'b1;
                        state_next    = S_DIFF;
                    end
                    else
                    begin
                        cmd.accept_wr = 1'b1;
                    end
                end
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_MULS;
            end
            S_MULS:
            begin
                cmd.start_mul = 1'b1;
                state_next    = S_MULW;
            end
            S_MULW:
            begin
                if (!stat.mul_busy)
                begin
                    state_next = S_YAWS;
                end
            end
            S_YAWS:
            begin
                cmd.start_yaw = 1'b1;
                state_next    = S_YAWW;
            end
            S_YAWW:
            begin
                if (!stat.cordic_busy)
                begin
                    state_next = S_BEARS;
                end
            end
            S_BEARS:
            begin
                cmd.start_bear = 1'b1;
                state_next     = S_BEARW;
            end
            S_BEARW:
            begin
                if (!stat.cordic_busy && !stat.sqrt_busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign request_ready = (state_reg == S_IDLE);
    assign result_valid  = valid_reg;

endmodule

// File: rtl/waypoint_follow_controller_unit.sv
// ----------------------------------------------------------------------------
// Waypoint follow controller unit
// Waypoint table, yaw and bearing by CORDIC, distance by square root, and the
// move / align / track / finished mode sequence for a unicycle robot.
// ----------------------------------------------------------------------------
// A waypoint write request is taken and gives no result. An odometry request
// runs ten products through one shared 32x32 multiplier, then yaw and
// bearing through one 16-step CORDIC in turn, with the 32-step square root
// for the distance running beside them. A new request is taken as soon as
// the result is in the output register, even while it waits to be taken.
module waypoint_follow_controller_unit #(
    parameter int WAYPOINT_DEPTH = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  request_valid,
    output logic                  request_ready,
    input  wfc_pkg::wfc_request_t request,
    output logic                  result_valid,
    input  logic                  result_ready,
    output wfc_pkg::wfc_result_t  result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

`include "waypoint_follow_controller_unit_macros.svh"

    wfc_pkg::wfc_cfg_t  cfg_reg;
    wfc_pkg::wfc_cmd_t  cmd;
    wfc_pkg::wfc_stat_t stat;
    logic               cfg_wr;
    logic [2:0]         reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tolerance      <= wfc_pkg::TOLERANCE_RST;
            cfg_reg.linear_speed   <= '0;
            cfg_reg.turn_speed     <= '0;
            cfg_reg.start_heading  <= '0;
            cfg_reg.waypoint_count <= 9'd1;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                wfc_pkg::REG_TOLERANCE:     cfg_reg.tolerance      <= pwdata[30:0];
                wfc_pkg::REG_LINEAR_SPEED:  cfg_reg.linear_speed   <= pwdata[15:0];
                wfc_pkg::REG_TURN_SPEED:    cfg_reg.turn_speed     <= pwdata[15:0];
                wfc_pkg::REG_START_HEADING: cfg_reg.start_heading  <= pwdata[15:0];
                wfc_pkg::REG_WAYPOINT_CNT:  cfg_reg.waypoint_count <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wfc_pkg::REG_TOLERANCE:     prdata = {1'b0, cfg_reg.tolerance};
            wfc_pkg::REG_LINEAR_SPEED:  prdata = {16'h0, cfg_reg.linear_speed};
            wfc_pkg::REG_TURN_SPEED:    prdata = {16'h0, cfg_reg.turn_speed};
            wfc_pkg::REG_START_HEADING: prdata = {16'h0, cfg_reg.start_heading};
            wfc_pkg::REG_WAYPOINT_CNT:  prdata = {23'h0, cfg_reg.waypoint_count};
            default:                    prdata = '0;
        endcase
    end

    wfc_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .request_valid  (request_valid),
        .request_action (request.action),
        .request_ready  (request_ready),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .cmd            (cmd),
        .stat           (stat)
    );

    wfc_datapath #(
        .WAYPOINT_DEPTH (WAYPOINT_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .request (request),
        .cfg     (cfg_reg),
        .result  (result)
    );

    `WFC_ASSERT_IMP(a_finish_idle, clk, rst_n,
        result_valid && (result.mode == wfc_pkg::MODE_FINISH),
        (result.forward_cmd == 16'sd0) && (result.turn_cmd == 16'sd0),
        "finished result carries a nonzero command")
    `WFC_ASSERT_IMP(a_reached_stop, clk, rst_n,
        result_valid && result.reached,
        (result.forward_cmd == 16'sd0) && (result.turn_cmd == 16'sd0),
        "reached result carries a nonzero command")
    `WFC_ASSERT_NXT(a_odom_busy, clk, rst_n,
        request_valid && request_ready && (request.action == wfc_pkg::ACT_ODOM),
        !request_ready,
        "odometry request did not hold off the next request")

endmodule
